// ===== hw/rtl/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, constants and the star-closure prefix function for the
// wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int C_NUM_CHARS   = 32;
    localparam int C_POS_W       = C_NUM_CHARS + 1;
    localparam int C_CLOS_LEVELS = $clog2(C_POS_W);
    localparam int C_DATA_W      = 64;
    localparam int C_ADDR_W      = 6;
    localparam int C_LEN_W       = 6;
    localparam int C_NUM_WORDS   = 4;
    localparam int C_QPTR_W      = 1;
    localparam int C_QCNT_W      = 2;

    localparam logic [C_QCNT_W-1:0] C_QDEPTH = 2'd2;

    localparam logic [7:0] C_ANY_RUN = 8'h2A;
    localparam logic [7:0] C_ANY_ONE = 8'h3F;
    localparam logic [7:0] C_NUL     = 8'h00;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] C_REG_BYTES_A = 3'd0;
    localparam logic [2:0] C_REG_BYTES_B = 3'd1;
    localparam logic [2:0] C_REG_BYTES_C = 3'd2;
    localparam logic [2:0] C_REG_BYTES_D = 3'd3;
    localparam logic [2:0] C_REG_LENGTH  = 3'd4;

    typedef logic [C_NUM_CHARS-1:0][7:0] t_pat_bytes;

    // pattern properties derived from the registers
    typedef struct packed {
        logic [C_NUM_CHARS-1:0] star_mask;  // '*' within effective length
        logic [C_NUM_CHARS-1:0] in_len;     // position below effective length
        logic [C_POS_W-1:0]     end_pos;    // one-hot effective length
    } t_pat_info;

    // classified item handed from front to back
    typedef struct packed {
        logic                   has_char;
        logic                   term_end;
        logic [C_NUM_CHARS-1:0] step_mask;  // positions whose char accepts the byte
    } t_cmd;

    // Closure over stars: bit j+1 is set whenever bit j is set and char j is '*'.
    // Done as a log-depth prefix (generate = v, propagate = star below).
    function automatic logic [C_POS_W-1:0] f_star_closure(
        input logic [C_POS_W-1:0]     v,
        input logic [C_NUM_CHARS-1:0] star
    );
        logic [C_POS_W-1:0] g;
        logic [C_POS_W-1:0] p;
        logic [C_POS_W-1:0] g_n;
        logic [C_POS_W-1:0] p_n;
        int                 d;
        g = v;
        p = {star, 1'b0};
        for (int lvl = 0; lvl < C_CLOS_LEVELS; lvl++) begin
            d   = 1 << lvl;
            g_n = g;
            p_n = p;
            for (int j = 0; j < C_POS_W; j++) begin
                if (j >= d) begin
                    g_n[j] = g[j] | (p[j] & g[j-d]);
                    p_n[j] = p[j] & p[j-d];
                end
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

endpackage

// ===== hw/rtl/wpm_cfg.sv =====
// ----------------------------------------------------------------------------
// wpm_cfg
// APB register file holding the pattern; derives star positions, the
// effective-length mask and the one-hot end position.
// ----------------------------------------------------------------------------
module wpm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wpm_pkg::C_ADDR_W-1:0] paddr,
    input  logic [wpm_pkg::C_DATA_W-1:0] pwdata,
    output logic [wpm_pkg::C_DATA_W-1:0] prdata,
    output logic                         pready,
    output wpm_pkg::t_pat_bytes          o_pat_bytes,
    output wpm_pkg::t_pat_info           o_pat_info,
    output logic                         o_cfg_wr
);
    import wpm_pkg::*;

    logic [C_NUM_WORDS-1:0][C_DATA_W-1:0] r_words;
    logic [C_LEN_W-1:0]                   r_len;
    logic [2:0]                           w_idx;
    logic                                 w_wr;
    logic [C_LEN_W-1:0]                   w_lim;
    logic [C_NUM_CHARS-1:0]               w_zero;
    logic [C_NUM_CHARS-1:0]               w_in_len;

    assign pready = 1'b1;
    assign w_idx  = paddr[C_ADDR_W-1:3];
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg_wr = w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_len   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                C_REG_BYTES_A: r_words[0] <= pwdata;
                C_REG_BYTES_B: r_words[1] <= pwdata;
                C_REG_BYTES_C: r_words[2] <= pwdata;
                C_REG_BYTES_D: r_words[3] <= pwdata;
                C_REG_LENGTH:  r_len      <= pwdata[C_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            C_REG_BYTES_A: prdata = r_words[0];
            C_REG_BYTES_B: prdata = r_words[1];
            C_REG_BYTES_C: prdata = r_words[2];
            C_REG_BYTES_D: prdata = r_words[3];
            C_REG_LENGTH:  prdata = {{(C_DATA_W-C_LEN_W){1'b0}}, r_len};
            default:       prdata = '0;
        endcase
    end

    assign o_pat_bytes = t_pat_bytes'(r_words);

    // a length above the pattern store is clamped
    assign w_lim = (r_len > C_LEN_W'(C_NUM_CHARS)) ? C_LEN_W'(C_NUM_CHARS) : r_len;

    // effective length ends at the clamp or at the first NUL byte
    always_comb begin
        for (int i = 0; i < C_NUM_CHARS; i++) begin
            w_zero[i] = (o_pat_bytes[i] == C_NUL);
        end
        for (int i = 0; i < C_NUM_CHARS; i++) begin
            w_in_len[i] = (C_LEN_W'(i) < w_lim)
                        && ((w_zero & ({C_NUM_CHARS{1'b1}} >> (C_NUM_CHARS - 1 - i))) == '0);
            o_pat_info.star_mask[i] = w_in_len[i] && (o_pat_bytes[i] == C_ANY_RUN);
        end
        o_pat_info.in_len     = w_in_len;
        o_pat_info.end_pos[0] = !w_in_len[0];
        for (int j = 1; j < C_NUM_CHARS; j++) begin
            o_pat_info.end_pos[j] = w_in_len[j-1] && !w_in_len[j];
        end
        o_pat_info.end_pos[C_NUM_CHARS] = w_in_len[C_NUM_CHARS-1];
    end

endmodule

// ===== hw/rtl/wpm_front.sv =====
// ----------------------------------------------------------------------------
// wpm_front
// Accepts text items, classifies them against the pattern and queues the
// resulting step commands for the back end.
// ----------------------------------------------------------------------------
module wpm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_has_char,
    input  logic [7:0]          i_text_byte,
    input  logic                i_term_end,
    input  wpm_pkg::t_pat_bytes i_pat_bytes,
    input  wpm_pkg::t_pat_info  i_pat_info,
    output logic                o_cmd_valid,
    output wpm_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_pop
);
    import wpm_pkg::*;

    t_cmd                r_q [C_QDEPTH];
    logic [C_QPTR_W-1:0] r_wp;
    logic [C_QPTR_W-1:0] r_rp;
    logic [C_QCNT_W-1:0] r_cnt;
    logic [C_QCNT_W-1:0] n_cnt;
    t_cmd                w_cmd;
    logic                w_acc;
    logic                w_enq;
    logic                w_deq;

    // a zero byte carries no character
    always_comb begin
        w_cmd.has_char = i_has_char && (i_text_byte != C_NUL);
        w_cmd.term_end = i_term_end;
        for (int i = 0; i < C_NUM_CHARS; i++) begin
            w_cmd.step_mask[i] = i_pat_info.in_len[i]
                && ((i_pat_bytes[i] == C_ANY_ONE) || (i_pat_bytes[i] == i_text_byte));
        end
    end

    assign o_full = (r_cnt == C_QDEPTH);
    assign w_acc  = i_push && !o_full;
    // items with neither character nor end mark change nothing: drop them
    assign w_enq  = w_acc && (w_cmd.has_char || w_cmd.term_end);
    assign w_deq  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_enq && !w_deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_enq && w_deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

endmodule

// ===== hw/rtl/wpm_back.sv =====
// ----------------------------------------------------------------------------
// wpm_back
// Holds the active-position vector, applies one step command per cycle (a term
// end waits while the result queue is full) and queues each term's match result.
// ----------------------------------------------------------------------------
module wpm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wpm_pkg::t_pat_info i_pat_info,
    input  logic               i_cfg_wr,
    input  logic               i_cmd_valid,
    input  wpm_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic               o_matched
);
    import wpm_pkg::*;

    logic [C_POS_W-1:0]  r_act;
    logic                r_restart;
    logic [C_POS_W-1:0]  w_restart_vec;
    logic [C_POS_W-1:0]  w_act;
    logic [C_POS_W-1:0]  w_step;
    logic [C_POS_W-1:0]  n_act;
    logic                w_match;
    logic                r_oq [C_QDEPTH];
    logic [C_QPTR_W-1:0] r_owp;
    logic [C_QPTR_W-1:0] r_orp;
    logic [C_QCNT_W-1:0] r_ocnt;
    logic [C_QCNT_W-1:0] n_ocnt;
    logic                w_res_push;
    logic                w_res_pop;

    // restart is applied lazily so it always sees the pattern now in force
    assign w_restart_vec = f_star_closure(C_POS_W'(1), i_pat_info.star_mask);
    assign w_act = r_restart ? w_restart_vec : r_act;

    always_comb begin
        w_step = {1'b0, w_act[C_NUM_CHARS-1:0] & i_pat_info.star_mask}
               | {w_act[C_NUM_CHARS-1:0] & i_cmd.step_mask, 1'b0};
        n_act  = i_cmd.has_char ? f_star_closure(w_step, i_pat_info.star_mask) : w_act;
    end

    assign w_match    = |(n_act & i_pat_info.end_pos);
    assign o_cmd_pop  = i_cmd_valid && (!i_cmd.term_end || (r_ocnt != C_QDEPTH));
    assign w_res_push = o_cmd_pop && i_cmd.term_end;
    assign w_res_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= 1'b1;
        end else if (i_cfg_wr) begin
            r_restart <= 1'b1;
        end else if (o_cmd_pop) begin
            r_restart <= i_cmd.term_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_act <= n_act;
        end
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (w_res_push && !w_res_pop) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (!w_res_push && w_res_pop) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (w_res_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_oq[r_owp] <= w_match;
        end
    end

    assign o_empty   = (r_ocnt == '0);
    assign o_matched = r_oq[r_orp];

endmodule

// ===== hw/rtl/wildcard_pattern_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// Glob match ('*' any run, '?' one char) of a byte-streamed term against a
// pattern of up to 32 characters held in APB registers.
// ----------------------------------------------------------------------------
// A term's end item is registered in the front command queue, then its result in the result queue.
// Throughput: one item per cycle while neither queue is full; the active-position
// step in the back end (compare, shift, star-closure prefix) is combinational.
// Reset (synchronous, active low): pattern and length cleared, both queues
// empty, position vector restarted at position zero plus star closure.
module wildcard_pattern_matcher_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_has_char,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_term_end,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_matched,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wpm_pkg::C_ADDR_W-1:0] paddr,
    input  logic [wpm_pkg::C_DATA_W-1:0] pwdata,
    output logic [wpm_pkg::C_DATA_W-1:0] prdata,
    output logic                         pready
);
    import wpm_pkg::*;

    t_pat_bytes w_pat_bytes;
    t_pat_info  w_pat_info;
    logic       w_cfg_wr;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_cmd_pop;

    wpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_pat_bytes (w_pat_bytes),
        .o_pat_info  (w_pat_info),
        .o_cfg_wr    (w_cfg_wr)
    );

    wpm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_has_char  (i_has_char),
        .i_text_byte (i_text_byte),
        .i_term_end  (i_term_end),
        .i_pat_bytes (w_pat_bytes),
        .i_pat_info  (w_pat_info),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    wpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pat_info  (w_pat_info),
        .i_cfg_wr    (w_cfg_wr),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_matched   (o_matched)
    );

    // a term end taken by the back end always leaves a result waiting
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_pop && w_cmd.term_end) |=> !empty)
        else $error("term end consumed without a queued result");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("back end took a command from an empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule
